FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HIDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HIDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hidf_pkg.sv
// Shared constants and types of the hashed index duplicate filter.
`timescale 1ns / 1ps

package hidf_pkg;

    localparam int MAX_INDEX_BITS_DEF = 16;
    localparam int VALUE_W            = 32;
    localparam int SLOT_W             = 17;
    localparam int CFG_W              = 5;
    localparam int S_TDATA_W          = 32;
    localparam int M_TDATA_W          = 24;
    localparam int EPOCH_W            = 8;
    localparam int Q_DEPTH            = 4;
    localparam int OUT_DEPTH          = 4;

    localparam logic [VALUE_W-1:0] HASH_MUL_LO    = 32'h4C95_7F2D;
    localparam logic [CFG_W-1:0]   INDEX_BITS_RST = 5'd16;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST     = {EPOCH_W{1'b1}};

    // Status from the back end to the front end
    typedef struct packed {
        logic clearing;
    } hidf_status_t;

endpackage

FILE: rtl/hidf_fifo.sv
// Small register FIFO with occupancy count.
`timescale 1ns / 1ps

module hidf_fifo
    import hidf_pkg::*;
#(
    parameter int WIDTH = SLOT_W,
    parameter int DEPTH = Q_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         pop,
    output logic [WIDTH-1:0]             rd_data,
    output logic                         not_empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data   = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

FILE: rtl/hidf_front.sv
// Front end: input acceptance, configuration register and two-stage slot hash.
`timescale 1ns / 1ps

module hidf_front
    import hidf_pkg::*;
#(
    parameter int MAX_INDEX_BITS = MAX_INDEX_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [VALUE_W-1:0]            s_value,
    input  logic                          s_start,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic [$clog2(Q_DEPTH+1)-1:0]  q_count,
    input  hidf_status_t                  status,
    output logic                          q_push,
    output logic [MAX_INDEX_BITS:0]       q_wdata
);

    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [CFG_W-1:0]          index_bits_reg;
    logic                      a_vld_reg;
    logic [VALUE_W-1:0]        a_inc_reg;
    logic                      a_start_reg;
    logic                      b_vld_reg;
    logic [MAX_INDEX_BITS-1:0] b_slot_reg;
    logic                      b_start_reg;
    logic [MAX_INDEX_BITS-1:0] mask;
    logic [2*VALUE_W-1:0]      prod;
    logic [CNT_W:0]            credit_used;
    logic                      in_take;

    // Keep the low index_bits bits; widths above the slot range saturate naturally
    always_comb
    begin
        for (int i = 0; i < MAX_INDEX_BITS; i++)
        begin
            mask[i] = (CFG_W'(i) < index_bits_reg);
        end
    end

    assign prod = {{VALUE_W{1'b0}}, a_inc_reg} * {{VALUE_W{1'b0}}, HASH_MUL_LO};

    // Reserve queue room for every item still in the hash stages
    assign credit_used = {1'b0, q_count} + (CNT_W+1)'(a_vld_reg) + (CNT_W+1)'(b_vld_reg);
    assign s_tready    = !status.clearing && (credit_used < (CNT_W+1)'(Q_DEPTH));
    assign in_take     = s_tvalid && s_tready;
    assign cfg_ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg <= INDEX_BITS_RST;
            a_vld_reg      <= 1'b0;
            b_vld_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                index_bits_reg <= cfg_data;
            end
            a_vld_reg <= in_take;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_inc_reg   <= s_value + VALUE_W'(1);
        a_start_reg <= s_start;
        b_slot_reg  <= prod[VALUE_W +: MAX_INDEX_BITS] & mask;
        b_start_reg <= a_start_reg;
    end

    assign q_push  = b_vld_reg;
    assign q_wdata = {b_start_reg, b_slot_reg};

endmodule

FILE: rtl/hidf_back.sv
// Back end: epoch-tagged seen memory, test-and-set with forwarding, clearing sweep.
`timescale 1ns / 1ps

module hidf_back
    import hidf_pkg::*;
#(
    parameter int MAX_INDEX_BITS = MAX_INDEX_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_vld,
    input  logic [MAX_INDEX_BITS:0]         q_data,
    output logic                            q_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]  out_count,
    output logic                            res_vld,
    output logic [SLOT_W-1:0]               res_slot,
    output hidf_status_t                    status
);

    localparam int MEM_DEPTH = 1 << MAX_INDEX_BITS;
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    state_t                    state_reg;
    logic [MAX_INDEX_BITS-1:0] clr_addr_reg;
    logic                      clr_wrap_reg;
    logic [EPOCH_W-1:0]        epoch_reg;
    logic                      c_vld_reg;
    logic [MAX_INDEX_BITS-1:0] c_slot_reg;
    logic [EPOCH_W-1:0]        c_epoch_reg;
    logic                      lw_vld_reg;
    logic [MAX_INDEX_BITS-1:0] lw_slot_reg;
    logic [EPOCH_W-1:0]        lw_tag_reg;
    logic [EPOCH_W-1:0]        rd_tag_reg;
    logic [EPOCH_W-1:0]        tag_mem [MEM_DEPTH];

    logic                      head_start;
    logic [MAX_INDEX_BITS-1:0] head_slot;
    logic [EPOCH_W-1:0]        epoch_use;
    logic                      room;
    logic                      wrap_hit;
    logic                      go_clear;
    logic                      clr_done;
    logic                      seen;
    logic                      mem_we;
    logic [MAX_INDEX_BITS-1:0] mem_waddr;
    logic [EPOCH_W-1:0]        mem_wdata;

    assign head_start = q_data[MAX_INDEX_BITS];
    assign head_slot  = q_data[MAX_INDEX_BITS-1:0];
    assign epoch_use  = head_start ? epoch_reg + EPOCH_W'(1) : epoch_reg;
    assign room       = ({1'b0, out_count} + (OCNT_W+1)'(c_vld_reg)) < (OCNT_W+1)'(OUT_DEPTH);
    assign wrap_hit   = head_start && (epoch_reg == EPOCH_LAST);
    assign q_pop      = (state_reg == ST_RUN) && q_vld && room && !wrap_hit;
    // Sweep only once the last write of the old epoch has landed
    assign go_clear   = (state_reg == ST_RUN) && q_vld && wrap_hit && !c_vld_reg;
    assign clr_done   = (clr_addr_reg == {MAX_INDEX_BITS{1'b1}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            clr_wrap_reg <= 1'b0;
            epoch_reg    <= '0;
            c_vld_reg    <= 1'b0;
            lw_vld_reg   <= 1'b0;
        end
        else
        begin
            c_vld_reg  <= q_pop;
            lw_vld_reg <= c_vld_reg;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + MAX_INDEX_BITS'(1);
                    if (clr_done)
                    begin
                        state_reg <= ST_RUN;
                        // After a wrap the pending batch start advances the epoch to one
                        epoch_reg <= clr_wrap_reg ? '0 : EPOCH_W'(1);
                    end
                end
                ST_RUN:
                begin
                    if (go_clear)
                    begin
                        state_reg    <= ST_CLEAR;
                        clr_addr_reg <= '0;
                        clr_wrap_reg <= 1'b1;
                    end
                    else if (q_pop)
                    begin
                        epoch_reg <= epoch_use;
                    end
                end
                default:
                begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            c_slot_reg  <= head_slot;
            c_epoch_reg <= epoch_use;
        end
        lw_slot_reg <= c_slot_reg;
        lw_tag_reg  <= c_epoch_reg;
    end

    assign mem_we    = (state_reg == ST_CLEAR) || c_vld_reg;
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : c_slot_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : c_epoch_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop)
        begin
            rd_tag_reg <= tag_mem[head_slot];
        end
    end

    // Forward the write of the previous cycle, which the read did not see
    assign seen = (rd_tag_reg == c_epoch_reg) ||
                  (lw_vld_reg && (lw_slot_reg == c_slot_reg) && (lw_tag_reg == c_epoch_reg));

    assign res_vld         = c_vld_reg;
    assign res_slot        = seen ? {SLOT_W{1'b1}} : SLOT_W'(c_slot_reg);
    assign status.clearing = (state_reg == ST_CLEAR);

endmodule

FILE: rtl/hashed_index_duplicate_filter_top.sv
// Top level of the hashed index duplicate filter.
`timescale 1ns / 1ps

// Each transaction on the slave stream carries a 32-bit value (s_tdata) and a batch-start
// flag (s_tuser). The value plus one is multiplied by 0x4C957F2D, the high 32 bits of the
// product are masked to index_bits low bits (saturated at MAX_INDEX_BITS), and the slot is
// checked against the set of slots already produced in the batch. One transaction leaves on
// the master stream per input: the slot, or -1 (all ones in 17 bits) for a repeat.
// Throughput is one item per clock while no clearing pass runs and m_tready keeps up;
// each result passes two hash stages, the slot queue, the memory test and the output
// queue. The seen set lives in a 2^MAX_INDEX_BITS x 8-bit epoch-tag memory with one
// read-modify-write per cycle, so a batch start only advances the epoch. After reset, and
// after every 255th batch start once the epoch runs out, a clearing pass writes the whole
// memory, with s_tready low meanwhile. The user must write index_bits (reset 16) through
// cfg_valid/cfg_data only while the block is idle; the block itself does not enforce it.
// A short queue separates the hash front end from the memory back end; a small output
// queue lets the block keep accepting while a finished result waits on m_tready.

module hashed_index_duplicate_filter_top
    import hidf_pkg::*;
#(
    parameter int MAX_INDEX_BITS = MAX_INDEX_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] value
    input  logic [0:0]            s_tuser,   // [0] batch_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [16:0] slot (signed), [23:17] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data   // [4:0] index_bits
);

    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int O_CNT_W = $clog2(OUT_DEPTH + 1);

    hidf_status_t              status;
    logic                      q_push;
    logic [MAX_INDEX_BITS:0]   q_wdata;
    logic                      q_pop;
    logic [MAX_INDEX_BITS:0]   q_rdata;
    logic                      q_vld;
    logic [Q_CNT_W-1:0]        q_count;
    logic                      res_vld;
    logic [SLOT_W-1:0]         res_slot;
    logic [SLOT_W-1:0]         out_head;
    logic [O_CNT_W-1:0]        out_count;
    logic                      out_pop;

    // Accept, hash and mask
    hidf_front #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_value    (s_tdata[VALUE_W-1:0]),
        .s_start    (s_tuser[0]),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_count    (q_count),
        .status     (status),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    // Decouple front and back
    hidf_fifo #(
        .WIDTH (MAX_INDEX_BITS + 1),
        .DEPTH (Q_DEPTH)
    ) u_slot_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .wr_data    (q_wdata),
        .pop        (q_pop),
        .rd_data    (q_rdata),
        .not_empty  (q_vld),
        .count      (q_count)
    );

    // Test and mark the slot in the seen memory
    hidf_back #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_vld      (q_vld),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .out_count  (out_count),
        .res_vld    (res_vld),
        .res_slot   (res_slot),
        .status     (status)
    );

    // Hold results until the master side takes them
    hidf_fifo #(
        .WIDTH (SLOT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_vld),
        .wr_data    (res_slot),
        .pop        (out_pop),
        .rd_data    (out_head),
        .not_empty  (m_tvalid),
        .count      (out_count)
    );

    assign out_pop = m_tvalid && m_tready;
    assign m_tdata = M_TDATA_W'(out_head);

endmodule

FILE: rtl/hidf_checker.sv
// Port-level checker for the duplicate filter and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hidf_checker
    import hidf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_W-1:0]      cfg_data
);

    logic [CFG_W-1:0] ib_reg;
    logic [4:0]       pend_reg;
    logic             s_take;
    logic             m_take;

    assign s_take = s_tvalid && s_tready;
    assign m_take = m_tvalid && m_tready;

    // Track the index width and the items still owed a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ib_reg   <= INDEX_BITS_RST;
            pend_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ib_reg <= cfg_data;
            end
            if (s_take && !m_take)
            begin
                pend_reg <= pend_reg + 5'd1;
            end
            else if (m_take && !s_take)
            begin
                pend_reg <= pend_reg - 5'd1;
            end
        end
    end

    `HIDF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `HIDF_ASSERT_NOW(a_out_pad, m_tvalid, m_tdata[M_TDATA_W-1:SLOT_W] == '0, "tdata padding not zero")
    `HIDF_ASSERT_NOW(a_no_extra, m_tvalid, pend_reg != 5'd0, "result without a pending input")
    `HIDF_ASSERT_NOW(a_slot_range, m_tvalid && !m_tdata[SLOT_W-1], (m_tdata[SLOT_W-2:0] >> ib_reg) == '0, "slot outside index range")

endmodule

bind hashed_index_duplicate_filter_top hidf_checker u_hidf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
);

FILE: tb/tb_hashed_index_duplicate_filter_top.sv
// Self-checking testbench for the hashed index duplicate filter top level.
`timescale 1ns / 1ps

module tb_hashed_index_duplicate_filter_top;
    import hidf_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 8;
    // The limit covers two clearing passes plus roughly 1650 items with a wide margin.
    localparam int CYCLE_LIMIT    = 800000;
    localparam int DRAIN_CYCLES   = 16;      // settle time so the block is idle before a register write
    localparam int HOLDOFF_AT     = 300;     // accepted inputs before the long output stall
    localparam int HOLDOFF_CYCLES = 400;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_ITEMS    = 165;
    localparam int SLOT_SPACE     = 1 << MAX_INDEX_BITS_DEF;

    localparam logic [SLOT_W-1:0] SLOT_REPEAT = {SLOT_W{1'b1}};

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               batch_start;
    } filter_item_t;

    // DUT ports
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [31:0] value
    logic [0:0]           s_tuser   = '0;   // [0] batch_start
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [16:0] slot (signed), [23:17] zero
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;   // [4:0] index_bits

    // Stimulus and scoreboard
    filter_item_t      pending_items[$];
    logic [SLOT_W-1:0] expected_slots[$];
    filter_item_t      next_item;
    logic [SLOT_W-1:0] want_slot;
    logic [SLOT_W-1:0] pred_slot;

    // Predictor state: each slot holds the tag of the batch that last marked it, so a
    // batch start only bumps the current tag instead of wiping the whole map.
    int unsigned       seen_tag[SLOT_SPACE];
    int unsigned       batch_tag      = 1;
    logic [CFG_W-1:0]  index_bits_cur = INDEX_BITS_RST;

    // Handshake flags, sampled at each rising edge and used by the falling-edge drivers
    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    logic idle_mode = 1'b1;
    logic hold_rx   = 1'b0;
    int   tx_gap    = 0;
    int   rx_gap    = 0;
    int   rx_draw;
    int   items_in    = 0;
    int   fail_count  = 0;
    int   cycle_count = 0;

    hashed_index_duplicate_filter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hash one value to its slot, test it against the current batch and mark it.
    // Return the slot when new, all ones when it was already produced in this batch.
    function automatic logic [SLOT_W-1:0] hash_and_mark(input logic [VALUE_W-1:0] value,
                                                        input logic batch_start);
        logic [VALUE_W-1:0]   bumped;
        logic [2*VALUE_W-1:0] product;
        logic [VALUE_W-1:0]   slot;
        int unsigned          width;
        if (batch_start)
            batch_tag++;
        bumped  = value + 32'd1;
        product = {{VALUE_W{1'b0}}, bumped} * {{VALUE_W{1'b0}}, HASH_MUL_LO};
        // Saturate oversized widths; a width of zero leaves an empty mask
        width   = (index_bits_cur > MAX_INDEX_BITS_DEF) ? MAX_INDEX_BITS_DEF : index_bits_cur;
        slot    = product[2*VALUE_W-1:VALUE_W] & ((32'd1 << width) - 32'd1);
        if (seen_tag[slot] == batch_tag)
            return SLOT_REPEAT;
        seen_tag[slot] = batch_tag;
        return slot[SLOT_W-1:0];
    endfunction

    task automatic queue_item(input logic [VALUE_W-1:0] value, input logic batch_start);
        filter_item_t it;
        it.value       = value;
        it.batch_start = batch_start;
        pending_items  = {pending_items, it};
    endtask

    // Queue batches of random length. Most values come from a small per-batch pool so
    // that repeats happen even at wide slot ranges; the rest are fully random. Now and
    // then drop the leading batch start or insert a stray one mid-batch.
    task automatic queue_batches(input int n_items, input int max_len);
        filter_item_t       it;
        logic [VALUE_W-1:0] pool[8];
        int                 left;
        int                 len;
        int                 k;
        left = n_items;
        while (left > 0) begin
            len = $urandom_range(1, max_len);
            if (len > left)
                len = left;
            for (k = 0; k < 8; k++)
                pool[k] = $urandom;
            for (k = 0; k < len; k++) begin
                if (k == 0)
                    it.batch_start = ($urandom_range(0, 7) != 0);
                else
                    it.batch_start = ($urandom_range(0, 31) == 0);
                it.value = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)] : $urandom;
                pending_items = {pending_items, it};
            end
            left -= len;
        end
    endtask

    // Wait until every queued item is accepted and every result has arrived, then let
    // the pipeline settle so the block is idle for a register write.
    task automatic wait_drained;
        do
            @(posedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_slots.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write index_bits through the configuration channel and update the predictor at
    // the edge where the transaction completes.
    task automatic set_index_bits(input logic [CFG_W-1:0] bits);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= bits;
        do
            @(posedge clk);
        while (!cfg_ready);
        index_bits_cur = bits;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Input driver: hold the item until its transaction completes, then wait out the
    // drawn gap and present the next pending item.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!s_tvalid || in_fire) begin
                if (tx_gap > 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end
                else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.value;
                    s_tuser  <= next_item.batch_start;
                    tx_gap   <= idle_mode ? $urandom_range(0, 3) : 0;
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output receiver: in idle mode draw a random stall after each result; drop ready for
    // the whole long hold-off.
    always @(negedge clk) begin
        if (hold_rx) begin
            m_tready <= 1'b0;
        end
        else if (out_fire) begin
            rx_draw = idle_mode ? $urandom_range(0, 3) : 0;
            rx_gap   <= rx_draw;
            m_tready <= (rx_draw == 0);
        end
        else if (rx_gap > 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= (rx_gap == 1);
        end
        else begin
            m_tready <= 1'b1;
        end
    end

    // Long output stall: once enough inputs have gone in, hold off the receiver while
    // the sender keeps offering, so the internal queues fill and s_tready drops.
    initial begin
        wait (items_in >= HOLDOFF_AT);
        hold_rx = 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
    end

    // Monitor: predict on every accepted input, check every accepted result against the
    // oldest prediction, and enforce the cycle limit.
    always @(posedge clk) begin
        in_fire  = rst_n && s_tvalid && s_tready;
        out_fire = rst_n && m_tvalid && m_tready;
        if (in_fire) begin
            pred_slot      = hash_and_mark(s_tdata[VALUE_W-1:0], s_tuser[0]);
            expected_slots = {expected_slots, pred_slot};
            items_in++;
        end
        if (out_fire) begin
            if (expected_slots.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_tdata);
                fail_count++;
            end
            else begin
                want_slot = expected_slots.pop_front();
                if (m_tdata !== {{(M_TDATA_W - SLOT_W){1'b0}}, want_slot}) begin
                    $display("%0t: slot mismatch, expected %h, actual %h",
                             $time, want_slot, m_tdata[SLOT_W-1:0]);
                    fail_count++;
                end
            end
        end
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("hashed_index_duplicate_filter_top test failed");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset width of 16: repeats of zero, wrap of all ones to the same slot as zero,
        // sign-bit values, and a batch start that frees slot zero again.
        queue_item(32'h0000_0000, 1'b1);
        queue_item(32'h0000_0000, 1'b0);
        queue_item(32'hFFFF_FFFF, 1'b0);
        queue_item(32'hFFFF_FFFE, 1'b0);
        queue_item(32'h7FFF_FFFF, 1'b0);
        queue_item(32'h8000_0000, 1'b0);
        queue_item(32'h1234_5678, 1'b0);
        queue_item(32'h0000_0000, 1'b1);
        wait_drained();

        // Zero width: everything lands on slot zero
        set_index_bits(5'd0);
        queue_item(32'hDEAD_BEEF, 1'b1);
        queue_item(32'h0000_0000, 1'b0);
        queue_item(32'hFFFF_FFFF, 1'b0);
        queue_item(32'h5555_5555, 1'b1);
        wait_drained();

        // Oversized width saturates to the full slot range
        set_index_bits(5'd31);
        queue_item(32'hA5A5_A5A5, 1'b1);
        queue_item(32'h5A5A_5A5A, 1'b0);
        queue_item(32'hA5A5_A5A5, 1'b0);
        queue_item(32'hFFFF_FFFF, 1'b0);
        wait_drained();

        // Narrow the width inside the running batch: the old marks still count
        set_index_bits(5'd1);
        queue_item(32'h1357_9BDF, 1'b0);
        queue_item(32'h2468_ACE0, 1'b0);
        queue_item(32'h0000_0000, 1'b0);
        queue_item(32'h0000_0003, 1'b0);
        queue_item(32'hCAFE_F00D, 1'b1);
        wait_drained();

        // Random phases across widths; one phase of tiny batches drives the batch count
        // past the epoch range so the block runs a second clearing pass.
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       set_index_bits(5'd16);
                1:       set_index_bits(5'd1);
                2:       set_index_bits(5'd31);
                3:       set_index_bits(5'd8);
                4:       set_index_bits(5'd12);
                5:       set_index_bits(5'd0);
                6:       set_index_bits(5'd17);
                7:       set_index_bits(5'd4);
                default: set_index_bits(CFG_W'($urandom_range(0, 31)));
            endcase
            idle_mode = (p % 4 != 3);
            queue_batches(PHASE_ITEMS, (p == 4) ? 2 : 16);
            wait_drained();
        end

        if (fail_count == 0)
            $display("hashed_index_duplicate_filter_top test passed");
        else
            $display("hashed_index_duplicate_filter_top test failed");
        $finish;
    end

endmodule
